// ----- hdl/clt_pkg.sv -----
// Shared types, token kind codes, character codes and classifiers for the tokenizer.
package clt_pkg;

    typedef logic [4:0] t_kind;

    localparam t_kind K_EOF      = 5'd0;
    localparam t_kind K_IDENT    = 5'd1;
    localparam t_kind K_IF       = 5'd2;
    localparam t_kind K_INTLIT   = 5'd10;
    localparam t_kind K_FLOATLIT = 5'd11;
    localparam t_kind K_STRLIT   = 5'd12;
    localparam t_kind K_PLUS     = 5'd13;
    localparam t_kind K_MINUS    = 5'd14;
    localparam t_kind K_STAR     = 5'd15;
    localparam t_kind K_SLASH    = 5'd16;
    localparam t_kind K_LPAREN   = 5'd17;
    localparam t_kind K_RPAREN   = 5'd18;
    localparam t_kind K_LBRACE   = 5'd19;
    localparam t_kind K_RBRACE   = 5'd20;
    localparam t_kind K_SEMI     = 5'd21;
    localparam t_kind K_COMMA    = 5'd22;
    localparam t_kind K_EQEQ     = 5'd23;
    localparam t_kind K_NE       = 5'd24;
    localparam t_kind K_LT       = 5'd25;
    localparam t_kind K_LE       = 5'd26;
    localparam t_kind K_GT       = 5'd27;
    localparam t_kind K_GE       = 5'd28;
    localparam t_kind K_ASSIGN   = 5'd29;
    localparam t_kind K_UNKNOWN  = 5'd30;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // keyword text packed first character in the low byte, in kind order from K_IF
    localparam logic [47:0] KW_TEXT [8] = '{
        48'h0000_0000_6669,  // if
        48'h0000_6573_6c65,  // else
        48'h0065_6c69_6877,  // while
        48'h0000_0072_6f66,  // for
        48'h6e72_7574_6572,  // return
        48'h0000_0074_6e69,  // int
        48'h0074_616f_6c66,  // float
        48'h0000_7261_6863   // char
    };

    typedef struct packed {
        t_kind       kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
    } t_token;

    typedef struct packed {
        logic [2:0]       count;
        t_token [3:0]     tok;
    } t_bundle;

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_ident_char(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_USCORE);
    endfunction

    function automatic t_kind ident_kind(input logic [15:0] rl, input logic [47:0] kw);
        t_kind k;
        k = K_IDENT;
        if (rl <= 16'd6) begin
            for (int i = 7; i >= 0; i--) begin
                if (KW_TEXT[i] == kw) begin
                    k = K_IF + 5'(i);
                end
            end
        end
        return k;
    endfunction

endpackage

// ----- hdl/c_like_source_tokenizer_top.sv -----
// Top level of the streaming C-subset tokenizer.
// One source byte is taken per clock while o_ready is high; each byte's
// tokens (up to four, for instance when end of source flushes a pending
// token) are registered in bundle register r_a, then r_b, and leave one
// per clock while i_ready is high. Sustained rate is one byte per clock
// while bytes average at most one token and i_ready stays high; that rate
// is set by the single token output and the two-bundle buffer ahead of it.
// Once both bundle slots are full, every byte waits, including one that
// yields no token. Lines and columns count from 1 in POSITION_BITS-wide
// counters that saturate and are reported capped at 65535.
module c_like_source_tokenizer_top
    import clt_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_has_char,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_line,
    output logic [15:0] o_token_column,
    output logic [15:0] o_token_length,
    output logic        o_last_result
);

    logic    accept;
    logic    load;
    t_bundle bundle;
    t_token  token;

    assign accept = i_valid && o_ready;
    // requests that produce no token only advance the lexer state
    assign load   = accept && (bundle.count != 3'd0);

    clt_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_char_code(i_char_code),
        .i_has_char (i_has_char),
        .i_is_last  (i_is_last),
        .o_bundle   (bundle)
    );

    clt_serializer u_serializer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (load),
        .i_bundle  (bundle),
        .o_in_ready(o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_token   (token),
        .o_last    (o_last_result)
    );

    assign o_token_kind   = token.kind;
    assign o_token_line   = token.line;
    assign o_token_column = token.column;
    assign o_token_length = token.length;

endmodule

// ----- hdl/clt_lexer.sv -----
// Lexer state registers and the per-byte token logic producing up to four tokens.
module clt_lexer
    import clt_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char_code,
    input  logic          i_has_char,
    input  logic          i_is_last,
    output t_bundle       o_bundle
);

    localparam int P = POSITION_BITS;
    localparam logic [P-1:0] POS_MAX = '1;
    localparam logic [P-1:0] POS_ONE = P'(1);

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_EQ, M_BANG, M_LT, M_GT
    } t_mode;

    typedef struct packed {
        logic [1:0]   cnt;
        t_token [1:0] tok;
    } t_flush;

    t_mode         r_mode, n_mode;
    logic [P-1:0]  r_line, n_line, r_col, n_col;
    logic [P-1:0]  r_sl, n_sl, r_sc, n_sc;
    logic [15:0]   r_rl, n_rl;
    logic [47:0]   r_kw, n_kw;

    function automatic logic [15:0] cap16(input logic [P-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [P-1:0] sat_pos(input logic [P-1:0] v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    function automatic logic [15:0] sat_len(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic t_token mk(input t_kind k, input logic [P-1:0] ln,
                                  input logic [P-1:0] cl, input logic [15:0] len);
        t_token t;
        t.kind   = k;
        t.line   = cap16(ln);
        t.column = cap16(cl);
        t.length = len;
        return t;
    endfunction

    // tokens released by leaving the held mode
    function automatic t_flush flush_tokens(input t_mode m, input logic [P-1:0] sl,
                                            input logic [P-1:0] sc, input logic [15:0] rl,
                                            input logic [47:0] kw, input logic at_end);
        t_flush       f;
        logic [32:0]  dsum;
        logic [P-1:0] dcol;
        f    = '0;
        dsum = {1'b0, 32'(sc)} + 33'(rl);
        dcol = (dsum > 33'(POS_MAX)) ? POS_MAX : dsum[P-1:0];
        unique case (m)
            M_IDENT: begin
                f.cnt    = 2'd1;
                f.tok[0] = mk(ident_kind(rl, kw), sl, sc, rl);
            end
            M_INT: begin
                f.cnt    = 2'd1;
                f.tok[0] = mk(K_INTLIT, sl, sc, rl);
            end
            M_DOT: begin
                // digits then a dot: integer, then the dot alone
                f.cnt    = 2'd2;
                f.tok[0] = mk(K_INTLIT, sl, sc, rl);
                f.tok[1] = mk(K_UNKNOWN, sl, dcol, 16'd1);
            end
            M_FRAC: begin
                f.cnt    = 2'd1;
                f.tok[0] = mk(K_FLOATLIT, sl, sc, rl);
            end
            M_STR: begin
                if (at_end) begin
                    f.cnt    = 2'd1;
                    f.tok[0] = mk(K_UNKNOWN, sl, sc, 16'd0);
                end
            end
            M_EQ: begin
                f.cnt    = 2'd1;
                f.tok[0] = mk(K_ASSIGN, sl, sc, 16'd1);
            end
            M_BANG: begin
                f.cnt    = 2'd1;
                f.tok[0] = mk(K_UNKNOWN, sl, sc, 16'd1);
            end
            M_LT: begin
                f.cnt    = 2'd1;
                f.tok[0] = mk(K_LT, sl, sc, 16'd1);
            end
            M_GT: begin
                f.cnt    = 2'd1;
                f.tok[0] = mk(K_GT, sl, sc, 16'd1);
            end
            default: begin
            end
        endcase
        return f;
    endfunction

    always_comb begin
        t_flush     f1;
        t_flush     f2;
        logic       to_idle;
        logic [2:0] cnt;
        t_token [3:0] tok;
        t_kind      two_kind;
        logic [7:0] c;

        c        = i_char_code;
        n_mode   = r_mode;
        n_line   = r_line;
        n_col    = r_col;
        n_sl     = r_sl;
        n_sc     = r_sc;
        n_rl     = r_rl;
        n_kw     = r_kw;
        cnt      = 3'd0;
        tok      = '0;
        to_idle  = 1'b0;
        two_kind = K_EQEQ;
        f1       = flush_tokens(r_mode, r_sl, r_sc, r_rl, r_kw, 1'b0);

        if (i_has_char) begin
            unique case (r_mode)
                M_IDENT: begin
                    if (is_ident_char(c)) begin
                        if (r_rl < 16'd6) begin
                            n_kw[{r_rl[2:0], 3'b000} +: 8] = c;
                        end
                        n_rl = sat_len(r_rl);
                    end else begin
                        to_idle = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_digit(c)) begin
                        n_rl = sat_len(r_rl);
                    end else if (c == CH_DOT) begin
                        n_mode = M_DOT;
                    end else begin
                        to_idle = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        n_rl   = sat_len(sat_len(r_rl));
                        n_mode = M_FRAC;
                    end else begin
                        to_idle = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_digit(c)) begin
                        n_rl = sat_len(r_rl);
                    end else begin
                        to_idle = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        tok[cnt[1:0]] = mk(K_STRLIT, r_sl, r_sc, r_rl);
                        cnt           = cnt + 3'd1;
                        n_mode        = M_IDLE;
                    end else begin
                        n_rl = sat_len(r_rl);
                    end
                end
                M_EQ, M_BANG, M_LT, M_GT: begin
                    unique case (r_mode)
                        M_EQ:    two_kind = K_EQEQ;
                        M_BANG:  two_kind = K_NE;
                        M_LT:    two_kind = K_LE;
                        default: two_kind = K_GE;
                    endcase
                    if (c == CH_EQ) begin
                        tok[cnt[1:0]] = mk(two_kind, r_sl, r_sc, 16'd2);
                        cnt           = cnt + 3'd1;
                        n_mode        = M_IDLE;
                    end else begin
                        to_idle = 1'b1;
                    end
                end
                default: to_idle = 1'b1;
            endcase

            if (to_idle) begin
                for (int i = 0; i < 2; i++) begin
                    if (2'(i) < f1.cnt) begin
                        tok[cnt[1:0]] = f1.tok[i];
                        cnt           = cnt + 3'd1;
                    end
                end
                n_mode = M_IDLE;
                unique case (c)
                    CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
                    end
                    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LPAREN, CH_RPAREN,
                    CH_LBRACE, CH_RBRACE, CH_SEMI, CH_COMMA: begin
                        unique case (c)
                            CH_PLUS:   tok[cnt[1:0]] = mk(K_PLUS, r_line, r_col, 16'd1);
                            CH_MINUS:  tok[cnt[1:0]] = mk(K_MINUS, r_line, r_col, 16'd1);
                            CH_STAR:   tok[cnt[1:0]] = mk(K_STAR, r_line, r_col, 16'd1);
                            CH_SLASH:  tok[cnt[1:0]] = mk(K_SLASH, r_line, r_col, 16'd1);
                            CH_LPAREN: tok[cnt[1:0]] = mk(K_LPAREN, r_line, r_col, 16'd1);
                            CH_RPAREN: tok[cnt[1:0]] = mk(K_RPAREN, r_line, r_col, 16'd1);
                            CH_LBRACE: tok[cnt[1:0]] = mk(K_LBRACE, r_line, r_col, 16'd1);
                            CH_RBRACE: tok[cnt[1:0]] = mk(K_RBRACE, r_line, r_col, 16'd1);
                            CH_SEMI:   tok[cnt[1:0]] = mk(K_SEMI, r_line, r_col, 16'd1);
                            default:   tok[cnt[1:0]] = mk(K_COMMA, r_line, r_col, 16'd1);
                        endcase
                        cnt = cnt + 3'd1;
                    end
                    CH_EQ, CH_BANG, CH_LT, CH_GT, CH_QUOTE: begin
                        unique case (c)
                            CH_EQ:   n_mode = M_EQ;
                            CH_BANG: n_mode = M_BANG;
                            CH_LT:   n_mode = M_LT;
                            CH_GT:   n_mode = M_GT;
                            default: n_mode = M_STR;
                        endcase
                        n_sl = r_line;
                        n_sc = r_col;
                        n_rl = (c == CH_QUOTE) ? 16'd0 : 16'd1;
                        n_kw = '0;
                    end
                    default: begin
                        if (is_alpha(c) || (c == CH_USCORE)) begin
                            n_mode = M_IDENT;
                            n_sl   = r_line;
                            n_sc   = r_col;
                            n_rl   = 16'd1;
                            n_kw   = 48'(c);
                        end else if (is_digit(c)) begin
                            n_mode = M_INT;
                            n_sl   = r_line;
                            n_sc   = r_col;
                            n_rl   = 16'd1;
                            n_kw   = '0;
                        end else begin
                            tok[cnt[1:0]] = mk(K_UNKNOWN, r_line, r_col, 16'd1);
                            cnt           = cnt + 3'd1;
                        end
                    end
                endcase
            end

            if (c == CH_LF) begin
                n_line = sat_pos(r_line);
                n_col  = POS_ONE;
            end else begin
                n_col = sat_pos(r_col);
            end
        end

        // end of source works on the state left by this byte
        f2 = flush_tokens(n_mode, n_sl, n_sc, n_rl, n_kw, 1'b1);
        if (i_is_last) begin
            for (int i = 0; i < 2; i++) begin
                if (2'(i) < f2.cnt) begin
                    tok[cnt[1:0]] = f2.tok[i];
                    cnt           = cnt + 3'd1;
                end
            end
            tok[cnt[1:0]] = mk(K_EOF, n_line, n_col, 16'd0);
            cnt           = cnt + 3'd1;
            n_mode        = M_IDLE;
            n_line        = POS_ONE;
            n_col         = POS_ONE;
            n_sl          = POS_ONE;
            n_sc          = POS_ONE;
            n_rl          = 16'd0;
            n_kw          = '0;
        end

        o_bundle.count = cnt;
        o_bundle.tok   = tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= POS_ONE;
            r_col  <= POS_ONE;
            r_sl   <= POS_ONE;
            r_sc   <= POS_ONE;
            r_rl   <= 16'd0;
            r_kw   <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_sl   <= n_sl;
            r_sc   <= n_sc;
            r_rl   <= n_rl;
            r_kw   <= n_kw;
        end
    end

endmodule

// ----- hdl/clt_serializer.sv -----
// Two-deep token bundle buffer that hands out one token per output request.
module clt_serializer
    import clt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_bundle i_bundle,
    output logic    o_in_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_token  o_token,
    output logic    o_last
);

    logic    r_a_valid, r_b_valid;
    t_bundle r_a, r_b;
    logic [1:0] r_idx;
    logic    pop, b_done, move, last;

    always_comb begin
        last       = ({1'b0, r_idx} == (r_b.count - 3'd1));
        pop        = r_b_valid && i_ready;
        b_done     = pop && last;
        move       = r_a_valid && (!r_b_valid || b_done);
        o_in_ready = !r_a_valid || move;
        o_valid    = r_b_valid;
        o_token    = r_b.tok[r_idx];
        o_last     = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_idx     <= 2'd0;
        end else begin
            if (i_load) begin
                r_a_valid <= 1'b1;
            end else if (move) begin
                r_a_valid <= 1'b0;
            end
            if (move) begin
                r_b_valid <= 1'b1;
                r_idx     <= 2'd0;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end else if (pop) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a <= i_bundle;
        end
        if (move) begin
            r_b <= r_a;
        end
    end

endmodule
